@@ design/rbfk_pkg.sv @@
// rbfk_pkg: shared types, command codes and fixed-point constants for the
// squared-exponential kernel block. No dependencies.
`timescale 1ns / 1ps
package rbfk_pkg;

   localparam int DIFF_W      = 33;
   localparam int SQ_W        = 48;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_ADDR_W  = 2;

   localparam logic [1:0] CMD_VALUE = 2'd0;
   localparam logic [1:0] CMD_DX    = 2'd1;
   localparam logic [1:0] CMD_DXP   = 2'd2;
   localparam logic [1:0] CMD_DXX   = 2'd3;

   localparam logic [31:0] INV_RESET = 32'd16777216;
   localparam logic [30:0] ONE_Q30   = 31'd1073741824;
   localparam logic [32:0] LOG2E_Q30 = 33'd1549082005;
   localparam logic [32:0] LN2_Q30   = 33'd744261118;
   localparam logic [32:0] RECIP3    = 33'h0AAAAAAAB;

   typedef enum logic [1:0] {FR_IDLE, FR_SQ, FR_LO, FR_HI} fr_state_type;

   typedef enum logic [3:0] {
      BK_IDLE, BK_Z, BK_G, BK_H1, BK_DIV, BK_H2, BK_H3, BK_MANT,
      BK_PRE, BK_LO, BK_HI, BK_DONE
   } bk_state_type;

   typedef struct packed {
      logic [1:0]               cmd;
      logic [SQ_W-1:0]          sq;
      logic signed [DIFF_W-1:0] d1;
      logic signed [DIFF_W-1:0] d2;
      logic                     delta;
   } job_type;

   // 2^(-j/8) in Q30
   function automatic logic [30:0] pow2_q30(input logic [2:0] j);
      logic [30:0] r;
      case (j)
         3'd0: r = 31'd1073741824;
         3'd1: r = 31'd984625594;
         3'd2: r = 31'd902905651;
         3'd3: r = 31'd827968132;
         3'd4: r = 31'd759250125;
         3'd5: r = 31'd696235436;
         3'd6: r = 31'd638450708;
         3'd7: r = 31'd585461881;
         default: r = 31'd0;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] diff_mag(input logic signed [DIFF_W-1:0] d);
      logic [DIFF_W-1:0] n;
      n = -d;
      return d[DIFF_W-1] ? n[31:0] : d[31:0];
   endfunction

endpackage

@@ design/rbfk_front.sv @@
// rbfk_front: accepts element pairs, accumulates the scaled squared distance
// and captures the selected differences. Depends on rbfk_pkg.
`timescale 1ns / 1ps
module rbfk_front #(
   parameter int MAX_DIM   = 16,
   parameter int DATA_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_cmd,
   input  logic [DATA_BITS-1:0]   req_x_elem,
   input  logic [DATA_BITS-1:0]   req_xp_elem,
   input  logic [3:0]             req_first_dim,
   input  logic [3:0]             req_second_dim,
   input  logic                   req_last_elem,
   input  logic [31:0]            inv_len_sq,
   output logic                   job_push,
   output rbfk_pkg::job_type      job,
   input  logic                   job_full
);
   import rbfk_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIM + 1);
   localparam logic signed [63:0] DMAX = 64'sh00000000FFFFFFFF;
   localparam logic signed [63:0] DMIN = -DMAX;

   fr_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [SQ_W-1:0] sq_ff;
   logic signed [DIFF_W-1:0] d1_ff, d2_ff;
   logic [31:0] mag_ff;
   logic [63:0] prod_ff;
   logic [31:0] lo_ff;
   logic last_ff, delta_ff;
   logic [1:0] cmd_ff;

   logic accept;
   logic signed [DATA_BITS:0] dfull;
   logic signed [63:0] d64;
   logic signed [DIFF_W-1:0] dclamp;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p, r;
   logic [56:0] sum;
   logic [SQ_W-1:0] sq_new;
   logic done_hi;

   assign accept = req_valid && (state_ff == FR_IDLE);
   assign req_stall = (state_ff != FR_IDLE);
   assign dfull = {req_x_elem[DATA_BITS-1], req_x_elem}
                - {req_xp_elem[DATA_BITS-1], req_xp_elem};
   assign d64 = 64'(dfull);

   always_comb begin
      if (d64 > DMAX) begin
         dclamp = DMAX[DIFF_W-1:0];
      end else if (d64 < DMIN) begin
         dclamp = DMIN[DIFF_W-1:0];
      end else begin
         dclamp = d64[DIFF_W-1:0];
      end
   end

   always_comb begin
      case (state_ff)
         FR_SQ: begin
            mul_a = mag_ff;
            mul_b = mag_ff;
         end
         FR_LO: begin
            mul_a = prod_ff[31:0];
            mul_b = inv_len_sq;
         end
         FR_HI: begin
            mul_a = prod_ff[63:32];
            mul_b = inv_len_sq;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   assign mul_p = 64'(mul_a) * 64'(mul_b);
   assign r = mul_p + 64'(lo_ff);
   assign sum = 57'(sq_ff) + 57'(r[63:8]);
   assign sq_new = (sum > 57'({SQ_W{1'b1}})) ? {SQ_W{1'b1}} : sum[SQ_W-1:0];
   assign done_hi = (state_ff == FR_HI) && !(last_ff && job_full);
   assign job_push = done_hi && last_ff;
   assign job = '{cmd: cmd_ff, sq: sq_new, d1: d1_ff, d2: d2_ff, delta: delta_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: begin
            if (accept) state_in = FR_SQ;
         end
         FR_SQ: state_in = FR_LO;
         FR_LO: state_in = FR_HI;
         FR_HI: begin
            if (done_hi) state_in = FR_IDLE;
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sq_ff  <= '0;
         d1_ff  <= '0;
         d2_ff  <= '0;
      end else if (accept) begin
         if (cnt_ff < CNT_W'(MAX_DIM)) begin
            if (8'(cnt_ff) == 8'(req_first_dim)) d1_ff <= dclamp;
            if (8'(cnt_ff) == 8'(req_second_dim)) d2_ff <= dclamp;
            cnt_ff <= cnt_ff + 1'b1;
         end
      end else if (done_hi) begin
         if (last_ff) begin
            cnt_ff <= '0;
            sq_ff  <= '0;
            d1_ff  <= '0;
            d2_ff  <= '0;
         end else begin
            sq_ff <= sq_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mag_ff   <= diff_mag(dclamp);
         last_ff  <= req_last_elem;
         cmd_ff   <= req_cmd;
         delta_ff <= (req_first_dim == req_second_dim);
      end
      if (state_ff == FR_SQ) prod_ff <= mul_p;
      if (state_ff == FR_SQ) lo_ff <= 32'd0;
      if (state_ff == FR_LO) lo_ff <= mul_p[63:32];
   end

endmodule

@@ design/rbfk_queue.sv @@
// rbfk_queue: short job queue between the accumulating front and the exp
// back end. Depends on rbfk_pkg.
`timescale 1ns / 1ps
module rbfk_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rbfk_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output rbfk_pkg::job_type pop_job
);
   import rbfk_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [PTR_W:0] count_ff;

   assign full = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem[wr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push && !full) wr_ff <= wr_ff + 1'b1;
         if (pop && pop_valid) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (PTR_W+1)'(push && !full) - (PTR_W+1)'(pop && pop_valid);
      end
   end

endmodule

@@ design/rbfk_back.sv @@
// rbfk_back: evaluates exp(-sum/2) and the selected kernel or derivative
// on one shared multiplier, then saturates into the result register.
// Depends on rbfk_pkg.
`timescale 1ns / 1ps
module rbfk_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [31:0]       inv_len_sq,
   input  logic              job_valid,
   input  rbfk_pkg::job_type job,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_kernel_value,
   output logic              rsp_saturated
);
   import rbfk_pkg::*;

   bk_state_type state_ff, state_in;
   logic [1:0] cmd_ff, pass_ff;
   logic [SQ_W-1:0] sq_ff;
   logic signed [DIFF_W-1:0] d1_ff, d2_ff;
   logic delta_ff, neg3_ff;
   logic [5:0] n_ff;
   logic [2:0] j_ff;
   logic [20:0] rem_ff;
   logic [26:0] g_ff;
   logic [30:0] a_ff, e_ff;
   logic [63:0] opa_ff, v_ff;
   logic [32:0] lo_ff;
   logic valid_ff, sat_ff;
   logic [31:0] word_ff;

   logic [31:0] ma;
   logic [32:0] mb, bsel;
   logic [64:0] prod;
   logic [63:0] r, delta64, m;
   logic [30:0] mant, e_new;
   logic big, neg, sat, tneg, neg3, out_free;
   logic [63:0] vs;
   logic [31:0] word;

   assign big = |sq_ff[SQ_W-1:22];
   assign out_free = !valid_ff || !rsp_stall;
   assign job_pop = (state_ff == BK_IDLE) && job_valid;

   always_comb begin
      if (cmd_ff == CMD_DXX) begin
         bsel = (pass_ff == 2'd2) ? {e_ff, 2'b00} : {1'b0, inv_len_sq};
      end else begin
         bsel = {2'b00, e_ff};
      end
   end

   always_comb begin
      case (state_ff)
         BK_Z: begin
            ma = 32'(sq_ff[21:0]);
            mb = LOG2E_Q30;
         end
         BK_G: begin
            ma = 32'(rem_ff);
            mb = LN2_Q30;
         end
         BK_H1: begin
            ma = 32'(g_ff);
            mb = 33'(ONE_Q30 - 31'(g_ff >> 2));
         end
         BK_DIV: begin
            ma = 32'(a_ff);
            mb = RECIP3;
         end
         BK_H2, BK_H3: begin
            ma = 32'(g_ff);
            mb = 33'(a_ff);
         end
         BK_MANT: begin
            ma = 32'(pow2_q30(j_ff));
            mb = 33'(a_ff);
         end
         BK_PRE: begin
            ma = diff_mag(d1_ff);
            mb = (cmd_ff == CMD_DXX) ? 33'(diff_mag(d2_ff)) : 33'(inv_len_sq);
         end
         BK_LO: begin
            ma = opa_ff[31:0];
            mb = bsel;
         end
         BK_HI: begin
            ma = opa_ff[63:32];
            mb = bsel;
         end
         default: begin
            ma = 32'd0;
            mb = 33'd0;
         end
      endcase
   end

   assign prod = 65'(ma) * 65'(mb);
   assign r = prod[63:0] + 64'(lo_ff);
   assign mant = prod[60:30];
   assign e_new = (big || n_ff == 6'd63) ? 31'd0 : (mant >> n_ff);
   assign delta64 = delta_ff ? 64'd16777216 : 64'd0;
   assign tneg = d1_ff[DIFF_W-1] ^ d2_ff[DIFF_W-1];

   always_comb begin
      neg3 = 1'b0;
      if (tneg) begin
         m = (r > ~delta64) ? '1 : r + delta64;
      end else if (r > delta64) begin
         m = r - delta64;
         neg3 = 1'b1;
      end else begin
         m = delta64 - r;
      end
   end

   always_comb begin
      case (cmd_ff)
         CMD_VALUE: neg = 1'b0;
         CMD_DX:    neg = d1_ff[DIFF_W-1];
         CMD_DXP:   neg = !d1_ff[DIFF_W-1];
         default:   neg = neg3_ff;
      endcase
      sat = 1'b0;
      vs = v_ff;
      if (neg) begin
         if (v_ff > 64'h80000000) begin
            vs = 64'h80000000;
            sat = 1'b1;
         end
         word = 32'd0 - vs[31:0];
      end else begin
         if (v_ff > 64'h7FFFFFFF) begin
            vs = 64'h7FFFFFFF;
            sat = 1'b1;
         end
         word = vs[31:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) state_in = BK_Z;
         end
         BK_Z:    state_in = BK_G;
         BK_G:    state_in = BK_H1;
         BK_H1:   state_in = BK_DIV;
         BK_DIV:  state_in = BK_H2;
         BK_H2:   state_in = BK_H3;
         BK_H3:   state_in = BK_MANT;
         BK_MANT: state_in = (cmd_ff == CMD_VALUE) ? BK_DONE : BK_PRE;
         BK_PRE:  state_in = BK_LO;
         BK_LO:   state_in = BK_HI;
         BK_HI: begin
            if (cmd_ff == CMD_DXX && pass_ff != 2'd2) begin
               state_in = BK_LO;
            end else begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_DONE && out_free) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            cmd_ff   <= job.cmd;
            sq_ff    <= job.sq;
            d1_ff    <= job.d1;
            d2_ff    <= job.d2;
            delta_ff <= job.delta;
         end
         BK_Z: begin
            n_ff   <= prod[52:47];
            j_ff   <= prod[46:44];
            rem_ff <= prod[43:23];
         end
         BK_G:    g_ff <= prod[50:24];
         BK_H1:   a_ff <= prod[60:30];
         BK_DIV:  a_ff <= ONE_Q30 - 31'(prod[64:33]);
         BK_H2:   a_ff <= ONE_Q30 - 31'(prod[64:31]);
         BK_H3:   a_ff <= ONE_Q30 - 31'(prod[64:30]);
         BK_MANT: begin
            e_ff <= e_new;
            v_ff <= 64'(e_new >> 14);
         end
         BK_PRE: begin
            opa_ff  <= prod[63:0];
            pass_ff <= 2'd0;
         end
         BK_LO: lo_ff <= prod[64:32];
         BK_HI: begin
            lo_ff <= 33'd0;
            if (cmd_ff != CMD_DXX) begin
               v_ff <= 64'(r[63:22]);
            end else if (pass_ff == 2'd0) begin
               opa_ff  <= m;
               neg3_ff <= neg3;
               pass_ff <= 2'd1;
            end else if (pass_ff == 2'd1) begin
               opa_ff  <= r;
               pass_ff <= 2'd2;
            end else begin
               v_ff <= r;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               word_ff <= word;
               sat_ff  <= sat;
            end
         end
         default: lo_ff <= 33'd0;
      endcase
   end

   assign rsp_valid = valid_ff;
   assign rsp_kernel_value = word_ff;
   assign rsp_saturated = sat_ff;

endmodule

@@ design/rbf_kernel_with_gradients.sv @@
// rbf_kernel_with_gradients: top level with the inverse length register,
// front accumulator, job queue and exp back end.
// Depends on rbfk_pkg, rbfk_front, rbfk_queue, rbfk_back.
`timescale 1ns / 1ps
// Streams one (x, x') element pair per request and, on the request marked
// last, returns one saturated Q16.16 kernel or derivative value. The front
// end accepts a request and then makes three passes of its 32x32 multiplier.
// The back end shares one 32x33 multiplier; first derivatives add the PRE,
// LO and HI states to the exp steps and the mixed second derivative repeats
// the LO and HI pair; a two-entry queue lets it run while the front
// accumulates the next vector pair. inv_len_sq answers at every CSR address.
module rbf_kernel_with_gradients #(
   parameter int MAX_DIM   = 16,
   parameter int DATA_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_cmd,
   input  logic [DATA_BITS-1:0]            req_x_elem,
   input  logic [DATA_BITS-1:0]            req_xp_elem,
   input  logic [3:0]                      req_first_dim,
   input  logic [3:0]                      req_second_dim,
   input  logic                            req_last_elem,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [31:0]                     rsp_kernel_value,
   output logic                            rsp_saturated,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rbfk_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import rbfk_pkg::*;

   logic [31:0] inv_ff;
   logic push, full, pop, q_valid;
   job_type push_job, pop_job;
   logic [CSR_ADDR_W-1:0] addr_unused;

   assign csr_pready = 1'b1;
   assign addr_unused = csr_paddr;
   assign csr_prdata = (addr_unused == '0) ? inv_ff : inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= INV_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         inv_ff <= csr_pwdata;
      end
   end

   rbfk_front #(.MAX_DIM(MAX_DIM), .DATA_BITS(DATA_BITS)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_cmd), .req_x_elem(req_x_elem), .req_xp_elem(req_xp_elem),
      .req_first_dim(req_first_dim), .req_second_dim(req_second_dim),
      .req_last_elem(req_last_elem), .inv_len_sq(inv_ff),
      .job_push(push), .job(push_job), .job_full(full)
   );

   rbfk_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_job(push_job), .full(full),
      .pop(pop), .pop_valid(q_valid), .pop_job(pop_job)
   );

   rbfk_back u_back (
      .clock(clock), .reset(reset), .inv_len_sq(inv_ff),
      .job_valid(q_valid), .job(pop_job), .job_pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_kernel_value(rsp_kernel_value), .rsp_saturated(rsp_saturated)
   );

endmodule

@@ tb/rbf_kernel_with_gradients_tb.sv @@
// rbf_kernel_with_gradients_tb: self-checking testbench for the kernel block.
// It runs a bit-exact predictor and a scoreboard against the DUT under random
// idling on both channels. Depends on rbfk_pkg and rbf_kernel_with_gradients.
`timescale 1ns / 1ps

module rbf_kernel_with_gradients_tb;
   import rbfk_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] INV_ADDR = '0;
   localparam int TOTAL_REQS = 1950;

   class kernel_scoreboard;
      bit [31:0] inv;
      int unsigned count;
      bit [63:0] sq;
      longint df1, df2;
      bit [31:0] exp_value[$];
      bit        exp_sat[$];
      int errors;
      int results;
      bit [63:0] pow2[8] = '{64'd1073741824, 64'd984625594, 64'd902905651,
                             64'd827968132, 64'd759250125, 64'd696235436,
                             64'd638450708, 64'd585461881};

      function void reset_state();
         inv = INV_RESET;
         clear_vec();
      endfunction

      function void clear_vec();
         count = 0;
         sq = 0;
         df1 = 0;
         df2 = 0;
      endfunction

      function bit [63:0] mul_shr(bit [63:0] a, bit [63:0] b, int s);
         bit [127:0] p;
         p = {64'b0, a} * {64'b0, b};
         return 64'(p >> s);
      endfunction

      function bit [63:0] magnitude(longint v);
         return v < 0 ? 64'(-v) : 64'(v);
      endfunction

      function bit [63:0] exp_neg_half(bit [63:0] s);
         bit [63:0] z, fr, rem, g, a, mant;
         int n;
         if (s >= 64'd4194304) return 64'd0;
         z = (s * 64'd1549082005) >> 23;
         n = int'(z >> 24);
         fr = z & 64'hFFFFFF;
         rem = fr & 64'h1FFFFF;
         g = (rem * 64'd744261118) >> 24;
         a = 64'd1073741824 - (g >> 2);
         a = 64'd1073741824 - (((g * a) >> 30) / 3);
         a = 64'd1073741824 - (((g * a) >> 30) >> 1);
         a = 64'd1073741824 - ((g * a) >> 30);
         mant = (pow2[fr[23:21]] * a) >> 30;
         return n >= 63 ? 64'd0 : (mant >> n);
      endfunction

      function void note_request(bit [1:0] cmd, bit [31:0] x, bit [31:0] xp,
                                 bit [3:0] d1, bit [3:0] d2, bit last);
         longint diff;
         bit [63:0] a, term, e, v, t, delta, m;
         bit neg, sat, tneg;
         neg = 0;
         sat = 0;
         diff = longint'($signed(x)) - longint'($signed(xp));
         a = magnitude(diff);
         term = mul_shr(a * a, 64'(inv), 40);
         sq = (term > 64'hFFFFFFFFFFFF - sq) ? 64'hFFFFFFFFFFFF : sq + term;
         if (count < 16) begin
            if (count == d1) df1 = diff;
            if (count == d2) df2 = diff;
            count++;
         end
         if (!last) return;
         e = exp_neg_half(sq);
         if (cmd == CMD_VALUE) begin
            v = e >> 14;
         end else if (cmd == CMD_DX || cmd == CMD_DXP) begin
            v = mul_shr(magnitude(df1) * 64'(inv), e, 54);
            neg = (df1 < 0) != (cmd == CMD_DXP);
         end else begin
            t = mul_shr(magnitude(df1) * magnitude(df2), 64'(inv), 32);
            delta = (d1 == d2) ? 64'd16777216 : 64'd0;
            tneg = (df1 < 0) != (df2 < 0);
            if (tneg) begin
               m = (t > ~64'd0 - delta) ? ~64'd0 : t + delta;
            end else if (t > delta) begin
               m = t - delta;
               neg = 1;
            end else begin
               m = delta - t;
            end
            v = mul_shr(mul_shr(m, 64'(inv), 32), e << 2, 32);
         end
         if (neg) begin
            if (v > 64'h80000000) begin
               v = 64'h80000000;
               sat = 1;
            end
            exp_value.push_back(32'(0) - v[31:0]);
         end else begin
            if (v > 64'h7FFFFFFF) begin
               v = 64'h7FFFFFFF;
               sat = 1;
            end
            exp_value.push_back(v[31:0]);
         end
         exp_sat.push_back(sat);
         clear_vec();
      endfunction

      function void report(string what);
         $display("tb: mismatch: %s", what);
         errors++;
      endfunction

      function void check_result(bit [31:0] value, bit sat);
         bit [31:0] ev;
         bit es;
         if (exp_value.size() == 0) begin
            report($sformatf("unexpected result %h", value));
            return;
         end
         ev = exp_value.pop_front();
         es = exp_sat.pop_front();
         results++;
         if (value !== ev) report($sformatf("kernel_value %h, want %h", value, ev));
         if (sat !== es) report($sformatf("saturated %b, want %b", sat, es));
      endfunction

      function int pending();
         return exp_value.size();
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_cmd = '0;
   logic [31:0] req_x_elem = '0;
   logic [31:0] req_xp_elem = '0;
   logic [3:0]  req_first_dim = '0;
   logic [3:0]  req_second_dim = '0;
   logic        req_last_elem = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [31:0] rsp_kernel_value;
   logic        rsp_saturated;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   kernel_scoreboard sb = new();
   bit idle_on = 1;
   int sent = 0;
   int sat_seen = 0;

   rbf_kernel_with_gradients DUT (.*);

   always #10 clock = ~clock;

   always @(negedge clock) rsp_stall <= idle_on && ($urandom_range(99) < 38);

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsp_saturated) sat_seen++;
         sb.check_result(rsp_kernel_value, rsp_saturated);
      end

   task automatic send_req(bit [1:0] cmd, bit [31:0] x, bit [31:0] xp,
                           bit [3:0] d1, bit [3:0] d2, bit last);
      while (idle_on && $urandom_range(99) < 38) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_cmd <= cmd;
      req_x_elem <= x;
      req_xp_elem <= xp;
      req_first_dim <= d1;
      req_second_dim <= d2;
      req_last_elem <= last;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, x, xp, d1, d2, last);
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_inv(bit [31:0] value);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= INV_ADDR;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_pwrite <= 0;
      csr_penable <= 0;
      @(negedge clock);
      csr_penable <= 1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value)
         sb.report($sformatf("inv_len_sq read %h, want %h", csr_prdata, value));
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      sb.inv = value;
   endtask

   task automatic send_vector(int len, bit [1:0] cmd, bit [3:0] d1, bit [3:0] d2,
                              int spread, bit wide);
      bit [31:0] x, xp;
      for (int i = 0; i < len; i++) begin
         x = $urandom();
         if (wide) xp = $urandom();
         else xp = x + $urandom_range(0, 2 * spread) - spread;
         send_req(cmd, x, xp, d1, d2, i == len - 1);
      end
   endtask

   task automatic random_phase(int count);
      int stop;
      int len;
      stop = sent + count;
      while (sent < stop) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 8);
         if ($urandom_range(9) == 0)
            send_vector(len, 2'($urandom()), 4'($urandom()), 4'($urandom()), 0, 1'b1);
         else if ($urandom_range(9) == 0)
            send_req(2'($urandom()), $urandom(), $urandom(), 4'($urandom()),
                     4'($urandom()), 1'($urandom_range(1)));
         else
            send_vector(len, 2'($urandom()), 4'($urandom_range(0, len)),
                        4'($urandom_range(0, len)), 1 << $urandom_range(2, 20), 1'b0);
      end
      drain();
   endtask

   initial begin
      sb.reset_state();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: every kind, equal points, large sum, unused dims, long vector
      send_req(CMD_VALUE, 32'h0001_0000, 32'h0001_0000, 4'd0, 4'd0, 1);
      send_req(CMD_DX, 32'h0000_8000, 32'h0000_0000, 4'd0, 4'd0, 1);
      send_req(CMD_DXP, 32'h0000_0000, 32'h0000_8000, 4'd0, 4'd0, 1);
      send_req(CMD_DXX, 32'h0000_4000, 32'h0000_0000, 4'd0, 4'd0, 1);
      send_req(CMD_DXX, 32'h0000_4000, 32'hFFFF_C000, 4'd0, 4'd1, 0);
      send_req(CMD_DXX, 32'hFFFF_C000, 32'h0000_4000, 4'd0, 4'd1, 1);
      send_req(CMD_VALUE, 32'h7FFF_FFFF, 32'h8000_0000, 4'd0, 4'd0, 1);
      send_req(CMD_DX, 32'h8000_0000, 32'h7FFF_FFFF, 4'd15, 4'd15, 1);
      send_vector(3, CMD_DXX, 4'd10, 4'd12, 1 << 12, 0);
      send_vector(18, CMD_DX, 4'd15, 4'd15, 1 << 8, 0);
      drain();
      write_inv(32'hFFFF_FFFF);
      send_req(CMD_DXX, 32'h0000_0000, 32'h0000_0000, 4'd0, 4'd0, 1);
      send_req(CMD_DX, 32'h0000_0100, 32'h0000_0000, 4'd0, 4'd0, 1);
      drain();
      write_inv(32'd0);
      send_req(CMD_DXX, 32'h7FFF_FFFF, 32'h8000_0000, 4'd0, 4'd0, 1);
      send_req(CMD_DXP, 32'h1234_5678, 32'h8765_4321, 4'd0, 4'd0, 1);
      drain();

      write_inv(INV_RESET);
      random_phase(400);
      write_inv(32'd1);
      random_phase(250);
      write_inv(32'hFFFF_FFFF);
      random_phase(250);
      write_inv($urandom_range(32'h0040_0000, 32'h0400_0000));
      idle_on = 0;
      random_phase(350);
      idle_on = 1;
      write_inv(32'd0);
      random_phase(200);
      write_inv($urandom());
      random_phase(200);
      write_inv($urandom_range(32'h0100_0000, 32'h1000_0000));
      random_phase(300);

      while (sb.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("tb: %0d requests sent, %0d results checked, %0d saturated",
               sent, sb.results, sat_seen);
      $display("tb: seven length-scale settings including zero and both extremes");
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end
endmodule
